FILE: sv/hts_pkg.sv
// Shared constants and types for the header/tail frame synchroniser.
// Used by hts_front, hts_queue, hts_back and header_tail_frame_sync.
`timescale 1ns / 1ps

package hts_pkg;

  localparam int FRAME_LEN   = 20;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = $clog2(FRAME_LEN);
  localparam int FILL_W      = $clog2(FRAME_LEN + 1);
  localparam int INDEX_OUT_W = 5;
  localparam int REG_IDX_W   = 4;
  localparam int REG_W       = 8;

  localparam logic [REG_IDX_W-1:0] REG_HEADER = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TAIL   = REG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hFF;

  // Element 0 is the oldest byte of a frame.
  typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_t;

  typedef struct packed {
    logic   push;
    frame_t frame;
  } push_t;

endpackage

FILE: sv/header_tail_frame_sync.sv
// Top level of the header/tail sliding-window frame synchroniser.
// Depends on hts_pkg, hts_front, hts_queue and hts_back.
`timescale 1ns / 1ps

// Channel  Handshake            Payload                            Moves
// -------  -------------------  ---------------------------------  ----------------
// input    in_valid / in_stall  rx_byte[7:0]                       one rx byte
// output   out_valid/out_stall  frame_byte, byte_index, frame_last one frame byte
// config   wr_en                wr_index[3:0], wr_data[7:0]        register write
//
// One input request is taken per cycle unless in_stall is high. A matched window
// of FRAME_LEN bytes is copied whole into a one-frame queue and unloaded by the
// output sequencer at one byte per cycle while out_stall is low; with the
// sequencer idle, the frame is registered into the queue, then into the output.
// The input stalls only when a byte would complete a match while the queue
// still holds an earlier frame; otherwise intake runs on during output stalls.
// Synchronous reset clears the fill count, the queue and the output valid and
// restores header 0x55 and tail 0xFF; the window itself is not cleared.

module header_tail_frame_sync (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [hts_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [hts_pkg::REG_W-1:0]         wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hts_pkg::BYTE_W-1:0]        rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hts_pkg::BYTE_W-1:0]        frame_byte,
  output logic [hts_pkg::INDEX_OUT_W-1:0]   byte_index,
  output logic                              frame_last
);

  hts_pkg::push_t  push;
  hts_pkg::frame_t q_frame;
  logic            q_valid;
  logic            pop;

  // Front end: window, fill count, header/tail check
  hts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_valid),
    .push_out (push)
  );

  // Decouples a matched frame from the one still draining
  hts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push),
    .pop     (pop),
    .q_valid (q_valid),
    .q_frame (q_frame)
  );

  // Back end: byte-by-byte unload with index and last marker
  hts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_frame    (q_frame),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .frame_last (frame_last)
  );

endmodule

FILE: sv/hts_front.sv
// Front end: byte intake, sliding window, fill count and header/tail match.
// Depends on hts_pkg; pushes matched frames to hts_queue.
`timescale 1ns / 1ps

module hts_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [hts_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [hts_pkg::REG_W-1:0]        wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hts_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                             q_full,
  output hts_pkg::push_t                   push_out
);

  // win[0] is the newest byte
  logic [hts_pkg::FRAME_LEN-1:0][hts_pkg::BYTE_W-1:0] win;
  logic [hts_pkg::FILL_W-1:0] fill;
  logic [hts_pkg::FILL_W-1:0] fill_inc;
  logic [hts_pkg::BYTE_W-1:0] header_byte;
  logic [hts_pkg::BYTE_W-1:0] tail_byte;
  logic                       match;
  logic                       accept;
  hts_pkg::frame_t            frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= hts_pkg::HEADER_RESET;
      tail_byte   <= hts_pkg::TAIL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        hts_pkg::REG_HEADER: header_byte <= wr_data[hts_pkg::BYTE_W-1:0];
        hts_pkg::REG_TAIL:   tail_byte   <= wr_data[hts_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign fill_inc = (fill == hts_pkg::FILL_W'(hts_pkg::FRAME_LEN)) ?
                    fill : fill + 1'b1;

  // Check is on the window as it stands once this byte is in.
  assign match = (fill_inc == hts_pkg::FILL_W'(hts_pkg::FRAME_LEN)) &&
                 (win[hts_pkg::FRAME_LEN-2] == header_byte) &&
                 (rx_byte == tail_byte);

  assign in_stall = match && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < hts_pkg::FRAME_LEN - 1; i++) begin
      frame[i] = win[hts_pkg::FRAME_LEN-2-i];
    end
    frame[hts_pkg::FRAME_LEN-1] = rx_byte;
  end

  assign push_out.push  = accept && match;
  assign push_out.frame = frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= match ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= {win[hts_pkg::FRAME_LEN-2:0], rx_byte};
    end
  end

endmodule

FILE: sv/hts_queue.sv
// One-frame holding queue between the front end and the output sequencer.
// Depends on hts_pkg.
`timescale 1ns / 1ps

module hts_queue (
  input  logic            clk,
  input  logic            rst,
  input  hts_pkg::push_t  push_in,
  input  logic            pop,
  output logic            q_valid,
  output hts_pkg::frame_t q_frame
);

  // Push only arrives while empty, pop only while full.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (push_in.push) begin
      q_valid <= 1'b1;
    end else if (pop) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      q_frame <= push_in.frame;
    end
  end

endmodule

FILE: sv/hts_back.sv
// Output sequencer: unloads a queued frame one byte per accepted request.
// Depends on hts_pkg.
`timescale 1ns / 1ps

module hts_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  hts_pkg::frame_t                   q_frame,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hts_pkg::BYTE_W-1:0]        frame_byte,
  output logic [hts_pkg::INDEX_OUT_W-1:0]   byte_index,
  output logic                              frame_last
);

  hts_pkg::frame_t          frm;
  logic [hts_pkg::IDX_W-1:0] idx;
  logic                      out_accept;

  assign out_accept = out_valid && !out_stall;
  assign frame_last = (idx == hts_pkg::IDX_W'(hts_pkg::FRAME_LEN - 1));
  assign pop        = q_valid && (!out_valid || (out_accept && frame_last));
  assign frame_byte = frm[0];
  assign byte_index = hts_pkg::INDEX_OUT_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (out_accept) begin
      if (frame_last) begin
        out_valid <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frm <= q_frame;
    end else if (out_accept) begin
      frm <= frm >> hts_pkg::BYTE_W;
    end
  end

endmodule

FILE: dv/header_tail_frame_sync_tb.sv
// Self-checking testbench for header_tail_frame_sync: random byte streams of
// framed and broken data against a cycle-free frame predictor. Needs hts_pkg.
`timescale 1ns / 1ps

module header_tail_frame_sync_tb;

  // Writes to this index land on no register and must be ignored.
  localparam logic [hts_pkg::REG_IDX_W-1:0] REG_SPARE_TOP = hts_pkg::REG_IDX_W'(15);
  localparam int SETTLE_CYCLES = 8;    // idle margin once the last byte is out
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int RX_TARGET     = 460;  // target count of input requests for the whole run

  typedef struct {
    logic [hts_pkg::BYTE_W-1:0]      data;
    logic [hts_pkg::INDEX_OUT_W-1:0] index;
    logic                            last;
  } frame_beat_t;

  // Frame predictor plus the queue of frame bytes still owed by the block.
  class frame_scoreboard;
    logic [hts_pkg::BYTE_W-1:0] header_val;
    logic [hts_pkg::BYTE_W-1:0] tail_val;
    logic [hts_pkg::BYTE_W-1:0] window [hts_pkg::FRAME_LEN];
    int                         wr_pos;
    int                         fill;
    frame_beat_t                owed [$];
    int                         errors;

    function void reset_state();
      header_val = hts_pkg::HEADER_RESET;
      tail_val   = hts_pkg::TAIL_RESET;
      wr_pos     = 0;
      fill       = 0;
      errors     = 0;
      owed.delete();
    endfunction

    function void set_register(logic [hts_pkg::REG_IDX_W-1:0] idx,
                               logic [hts_pkg::REG_W-1:0] value);
      if (idx == hts_pkg::REG_HEADER) begin
        header_val = value;
      end else if (idx == hts_pkg::REG_TAIL) begin
        tail_val = value;
      end
    endfunction

    // One accepted rx byte: slide the window and, on a full header..tail
    // match, queue the whole window oldest first.
    function void note_rx_byte(logic [hts_pkg::BYTE_W-1:0] value);
      int          oldest;
      int          newest;
      frame_beat_t beat;
      window[wr_pos] = value;
      wr_pos = (wr_pos + 1) % hts_pkg::FRAME_LEN;
      if (fill < hts_pkg::FRAME_LEN) fill++;
      if (fill < hts_pkg::FRAME_LEN) return;
      oldest = wr_pos;
      newest = (wr_pos + hts_pkg::FRAME_LEN - 1) % hts_pkg::FRAME_LEN;
      if (window[oldest] != header_val || window[newest] != tail_val) return;
      for (int i = 0; i < hts_pkg::FRAME_LEN; i++) begin
        beat.data  = window[(oldest + i) % hts_pkg::FRAME_LEN];
        beat.index = hts_pkg::INDEX_OUT_W'(i);
        beat.last  = (i == hts_pkg::FRAME_LEN - 1);
        owed.push_back(beat);
      end
      fill = 0;
    endfunction

    function void check_frame_byte(logic [hts_pkg::BYTE_W-1:0] data,
                                   logic [hts_pkg::INDEX_OUT_W-1:0] index,
                                   logic last);
      frame_beat_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: stray frame byte: expected none, actual data %02h index %0d last %0b",
                 $time, data, index, last);
        return;
      end
      want = owed.pop_front();
      if (data !== want.data) begin
        errors++;
        $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                 $time, want.data, data);
      end
      if (index !== want.index) begin
        errors++;
        $display("%0t: byte_index mismatch: expected %0d, actual %0d",
                 $time, want.index, index);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            wr_en;
  logic [hts_pkg::REG_IDX_W-1:0]   wr_index;
  logic [hts_pkg::REG_W-1:0]       wr_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [hts_pkg::BYTE_W-1:0]      rx_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [hts_pkg::BYTE_W-1:0]      frame_byte;
  logic [hts_pkg::INDEX_OUT_W-1:0] byte_index;
  logic                            frame_last;

  // Knobs the stimulus process turns; the receiver only reads them, except
  // that it clears hold_req once it has started counting the hold-off.
  logic sender_gaps;
  logic steady_out;
  logic hold_req;
  int   rx_sent;

  frame_scoreboard sb;

  always #1 clk = ~clk;

  header_tail_frame_sync dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .frame_last (frame_last)
  );

  // Receiver: drives out_stall on the falling edge. A hold-off request turns
  // into a fixed run of stalled cycles, counted here; otherwise it stalls in
  // about a quarter of cycles, or never while steady_out is set.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (steady_out) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  // Output monitor: a frame byte moves on a rising edge with valid high and
  // stall low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_frame_byte(frame_byte, byte_index, frame_last);
    end
  end

  // Every task below starts and ends on a falling edge.
  task automatic send_rx_byte(input logic [hts_pkg::BYTE_W-1:0] value);
    if (sender_gaps) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx_byte(value);
    rx_sent++;
    @(negedge clk);
  endtask

  // Sender goes quiet until the block owes nothing, then lets it settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes only ever happen with the block drained.
  task automatic write_register(input logic [hts_pkg::REG_IDX_W-1:0] idx,
                                input logic [hts_pkg::REG_W-1:0] value);
    drain_results();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(negedge clk);
    wr_en    <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // A frame as a link would send it: optional line noise, the header, a
  // random body and the tail. Some frames are spoilt (bad header, bad tail,
  // short body) so that the window has to keep hunting.
  task automatic send_frame(input logic [hts_pkg::BYTE_W-1:0] hdr,
                            input logic [hts_pkg::BYTE_W-1:0] tl);
    int noise;
    int flaw;
    int body_len;
    noise    = ($urandom_range(99) < 50) ? 0 : $urandom_range(1, 6);
    flaw     = $urandom_range(99);
    body_len = (flaw >= 16 && flaw < 22) ? $urandom_range(1, hts_pkg::FRAME_LEN - 3) :
               hts_pkg::FRAME_LEN - 2;
    repeat (noise) send_rx_byte(hts_pkg::BYTE_W'($urandom_range(255)));
    send_rx_byte(flaw < 8 ? ~hdr : hdr);
    repeat (body_len) send_rx_byte(hts_pkg::BYTE_W'($urandom_range(255)));
    send_rx_byte((flaw >= 8 && flaw < 16) ? ~tl : tl);
  endtask

  initial begin : stimulus
    logic [hts_pkg::BYTE_W-1:0] hdr_set [5];
    logic [hts_pkg::BYTE_W-1:0] tl_set  [5];
    logic [hts_pkg::BYTE_W-1:0] opening [hts_pkg::FRAME_LEN + 5];
    int                         phase_end;

    rst         = 1'b1;
    wr_en       = 1'b0;
    wr_index    = '0;
    wr_data     = '0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    sender_gaps = 1'b1;
    steady_out  = 1'b0;
    hold_req    = 1'b0;
    rx_sent     = 0;
    sb = new;
    sb.reset_state();

    // Header/tail pairs per phase: extremes both ways round, header equal
    // to tail, a random pair, and back to the reset values.
    hdr_set = '{8'h00, 8'hFF, 8'hA5, 8'h00, hts_pkg::HEADER_RESET};
    tl_set  = '{8'hFF, 8'h00, 8'hA5, 8'h00, hts_pkg::TAIL_RESET};
    hdr_set[3] = hts_pkg::BYTE_W'($urandom_range(255));
    tl_set[3]  = hts_pkg::BYTE_W'($urandom_range(255));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening on the reset registers: no result while the window
    // is part full, a frame whose body holds the extremes and stray header
    // and tail values, then trailing bytes that must not re-match.
    opening = '{8'h55, 8'h00, 8'hFF, 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hFF, 8'h00,
                8'h55, 8'hAA, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'hFF, 8'h55, 8'h00, 8'hFF,
                8'hFF, 8'h55, 8'h00, 8'hFF, 8'hFF};
    foreach (opening[k]) send_rx_byte(opening[k]);

    // Unknown index: the predictor ignores it, so must the block.
    write_register(REG_SPARE_TOP, 8'h00);

    for (int p = 0; p < 5; p++) begin
      write_register(hts_pkg::REG_HEADER, hdr_set[p]);
      write_register(hts_pkg::REG_TAIL, tl_set[p]);
      write_register(hts_pkg::REG_IDX_W'($urandom_range(2, 15)),
                     hts_pkg::REG_W'($urandom_range(255)));
      phase_end = 25 + (p + 1) * (RX_TARGET - 25) / 5;

      if (p == 0) begin
        // Receiver holds off while back-to-back frames keep coming: the
        // one-frame queue fills and the third match stalls intake.
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
        repeat (3) begin
          send_rx_byte(hdr_set[p]);
          repeat (hts_pkg::FRAME_LEN - 2) send_rx_byte(hts_pkg::BYTE_W'($urandom_range(255)));
          send_rx_byte(tl_set[p]);
        end
        sender_gaps = 1'b1;
        drain_results();
      end
      if (p == 2) begin
        // A stretch with no idling on either side.
        sender_gaps = 1'b0;
        steady_out  = 1'b1;
      end

      while (rx_sent < phase_end) begin
        if ($urandom_range(99) < 15) begin
          send_rx_byte(hts_pkg::BYTE_W'($urandom_range(255)));
        end else begin
          send_frame(hdr_set[p], tl_set[p]);
        end
        // Now and then the sender waits for the block to empty.
        if ($urandom_range(99) < 5) drain_results();
      end

      sender_gaps = 1'b1;
      steady_out  = 1'b0;
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d frame bytes expected but never delivered", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far below this.
  initial begin : watchdog
    #400000;
    $display("%0t: timeout, %0d frame bytes still owed", $time, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
sv/hts_pkg.sv
sv/hts_front.sv
sv/hts_queue.sv
sv/hts_back.sv
sv/header_tail_frame_sync.sv
dv/header_tail_frame_sync_tb.sv
